### hw/rtl/mtrd_pkg.sv
package mtrd_pkg;

  // Geometry of the generator state
  localparam int unsigned StateWords = 624;
  localparam int unsigned AddrW      = 10;
  localparam logic [AddrW-1:0] LastIdx     = AddrW'(StateWords - 1);
  localparam logic [AddrW-1:0] TwistOffset = AddrW'(397);
  localparam logic [AddrW-1:0] StateDepth  = AddrW'(StateWords);

  // Twist, seeding and tempering constants
  localparam logic [31:0] MatA        = 32'h9908_b0df;
  localparam logic [31:0] HiMask      = 32'h8000_0000;
  localparam logic [31:0] LoMask      = 32'h7fff_ffff;
  localparam logic [31:0] TemperB     = 32'h9d2c_5680;
  localparam logic [31:0] TemperC     = 32'hefc6_0000;
  localparam logic [31:0] InitMult    = 32'd1812433253;
  localparam logic [31:0] DefaultSeed = 32'd5489;

  // Request codes
  localparam logic ActDraw   = 1'b0;
  localparam logic ActReseed = 1'b1;

  typedef struct packed {
    logic        action;
    logic [30:0] range_limit;
  } in_item_t;

  typedef struct packed {
    logic [30:0] ranged_value;
    logic [31:0] raw_word;
  } out_item_t;

  // Result request from the sequencer to the output pipeline
  typedef struct packed {
    logic        vld;
    logic        zero;
    logic [30:0] limit;
  } res_req_t;

  // Memory write port
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [31:0]      data;
  } mem_wr_t;

  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] mix;
    logic [31:0] tw;
    mix = (cur & HiMask) | (nxt & LoMask);
    tw  = (mix >> 1) ^ (nxt[0] ? MatA : 32'd0);
    return far ^ tw;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### hw/rtl/mtrd_state_ram.sv
module mtrd_state_ram (
  input  logic                           clk,
  input  mtrd_pkg::mem_wr_t              wr,
  input  logic [mtrd_pkg::AddrW-1:0]     ra_addr,
  input  logic [mtrd_pkg::AddrW-1:0]     rb_addr,
  output logic [31:0]                    ra_data,
  output logic [31:0]                    rb_data
);

  logic [31:0] mem [mtrd_pkg::StateWords];

  // Write one word
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered reads on both ports
  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

### hw/rtl/mtrd_out_stage.sv
module mtrd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mtrd_pkg::res_req_t    req,
  input  logic [31:0]           rd_word,
  output logic                  out_valid,
  output mtrd_pkg::out_item_t   out_data
);

  logic        v0_r;
  logic        zero0_r;
  logic [30:0] lim0_r;
  logic        v1_r;
  logic [31:0] y1_r;
  logic [30:0] lim1_r;
  logic        out_valid_r;
  mtrd_pkg::out_item_t out_data_r;
  logic [62:0] prod;

  assign prod = {31'd0, y1_r} * {32'd0, lim1_r};

  // Control flags of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= req.vld;
      v1_r        <= v0_r;
      out_valid_r <= v1_r;
    end
  end

  // Hold request, temper the word read, then scale by the limit
  always_ff @(posedge clk) begin
    zero0_r                 <= req.zero;
    lim0_r                  <= req.limit;
    y1_r                    <= zero0_r ? 32'd0 : mtrd_pkg::temper(rd_word);
    lim1_r                  <= zero0_r ? 31'd0 : lim0_r;
    out_data_r.raw_word     <= y1_r;
    out_data_r.ranged_value <= prod[62:32];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/mtrd_ctrl.sv
module mtrd_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  mtrd_pkg::in_item_t             in_data,
  output logic                           busy,
  input  logic                           cfg_valid,
  input  logic [31:0]                    cfg_data,
  output mtrd_pkg::mem_wr_t              wr,
  output logic [mtrd_pkg::AddrW-1:0]     ra_addr,
  output logic [mtrd_pkg::AddrW-1:0]     rb_addr,
  input  logic [31:0]                    ra_data,
  input  logic [31:0]                    rb_data,
  output mtrd_pkg::res_req_t             req
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_ADD,
    S_TW_PRIME,
    S_TW_RD,
    S_TW_WR,
    S_DRAW
  } state_t;

  localparam int unsigned AW = mtrd_pkg::AddrW;

  state_t        state_r, state_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [AW-1:0] wleft_r, wleft_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          seeded_r, seeded_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [30:0]   limit_r, limit_nxt;
  logic          draw_after_r, draw_after_nxt;

  logic [AW-1:0] next_idx;
  logic [AW-1:0] far_sum;
  logic [AW-1:0] far_idx;
  logic [31:0]   seed_mix;
  logic [63:0]   seed_prod;
  logic [31:0]   seed_word;

  // Neighbour and far addresses of the twist step
  assign next_idx  = (idx_r == mtrd_pkg::LastIdx) ? '0 : idx_r + AW'(1);
  assign far_sum   = idx_r + mtrd_pkg::TwistOffset;
  assign far_idx   = (far_sum >= mtrd_pkg::StateDepth) ? far_sum - mtrd_pkg::StateDepth
                                                       : far_sum;
  // Seeding recurrence, split over a multiply and an add state
  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_prod = {32'd0, mtrd_pkg::InitMult} * {32'd0, seed_mix};
  assign seed_word = prod_r + {{(32-AW){1'b0}}, idx_r};

  always_comb begin
    state_nxt      = state_r;
    seed_nxt       = cfg_valid ? cfg_data : seed_r;
    wleft_nxt      = wleft_r;
    wptr_nxt       = wptr_r;
    seeded_nxt     = seeded_r;
    idx_nxt        = idx_r;
    prev_nxt       = prev_r;
    prod_nxt       = prod_r;
    cur_nxt        = cur_r;
    limit_nxt      = limit_r;
    draw_after_nxt = draw_after_r;
    wr             = '0;
    ra_addr        = wptr_r;
    rb_addr        = '0;
    req            = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          limit_nxt = in_data.range_limit;
          if (in_data.action == mtrd_pkg::ActReseed) begin
            wr             = '{en: 1'b1, addr: '0, data: seed_r};
            prev_nxt       = seed_r;
            idx_nxt        = AW'(1);
            draw_after_nxt = 1'b0;
            state_nxt      = S_SEED_MUL;
          end else if (wleft_r != AW'(1)) begin
            // Draw straight from the current state
            ra_addr   = wptr_r;
            req       = '{vld: 1'b1, zero: 1'b0, limit: in_data.range_limit};
            wptr_nxt  = wptr_r + AW'(1);
            wleft_nxt = wleft_r - AW'(1);
          end else if (!seeded_r) begin
            wr             = '{en: 1'b1, addr: '0, data: mtrd_pkg::DefaultSeed};
            prev_nxt       = mtrd_pkg::DefaultSeed;
            idx_nxt        = AW'(1);
            draw_after_nxt = 1'b1;
            state_nxt      = S_SEED_MUL;
          end else begin
            state_nxt = S_TW_PRIME;
          end
        end
      end
      S_SEED_MUL: begin
        prod_nxt  = seed_prod[31:0];
        state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        wr       = '{en: 1'b1, addr: idx_r, data: seed_word};
        prev_nxt = seed_word;
        if (idx_r == mtrd_pkg::LastIdx) begin
          seeded_nxt = 1'b1;
          wleft_nxt  = AW'(1);
          if (draw_after_r) begin
            state_nxt = S_TW_PRIME;
          end else begin
            req       = '{vld: 1'b1, zero: 1'b1, limit: '0};
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SEED_MUL;
        end
      end
      S_TW_PRIME: begin
        ra_addr   = '0;
        idx_nxt   = '0;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        // The first step picks up word zero from the priming read
        if (idx_r == '0) begin
          cur_nxt = ra_data;
        end
        ra_addr   = next_idx;
        rb_addr   = far_idx;
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        wr      = '{en: 1'b1, addr: idx_r,
                    data: mtrd_pkg::twist_word(cur_r, ra_data, rb_data)};
        cur_nxt = ra_data;
        if (idx_r == mtrd_pkg::LastIdx) begin
          state_nxt = S_DRAW;
        end else begin
          idx_nxt   = next_idx;
          state_nxt = S_TW_RD;
        end
      end
      S_DRAW: begin
        // First word of the fresh state
        ra_addr   = '0;
        req       = '{vld: 1'b1, zero: 1'b0, limit: limit_r};
        wptr_nxt  = AW'(1);
        wleft_nxt = mtrd_pkg::StateDepth;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seed_r       <= mtrd_pkg::DefaultSeed;
      wleft_r      <= AW'(1);
      wptr_r       <= '0;
      seeded_r     <= 1'b0;
      draw_after_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      seed_r       <= seed_nxt;
      wleft_r      <= wleft_nxt;
      wptr_r       <= wptr_nxt;
      seeded_r     <= seeded_nxt;
      draw_after_r <= draw_after_nxt;
      idx_r        <= idx_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    prod_r  <= prod_nxt;
    cur_r   <= cur_nxt;
    limit_r <= limit_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/mersenne_twister_ranged_draw_top.sv
// A draw's result passes the registers v0_r, v1_r and out_valid_r; draws stream one per cycle
// while busy is low. Every 624th draw first regenerates the state, reading and then writing
// each word through the state memory's read and write ports.
// Reseed: each word passes a multiply and an add state; the result is zeros.
// Reset (rst_n low, synchronous) sets seed 5489 and marks the state unseeded; the first
// draw then seeds and regenerates. Results are shown for one cycle and cannot be stalled.
module mersenne_twister_ranged_draw_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mtrd_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output mtrd_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  mtrd_pkg::mem_wr_t                wr;
  logic [mtrd_pkg::AddrW-1:0]       ra_addr;
  logic [mtrd_pkg::AddrW-1:0]       rb_addr;
  logic [31:0]                      ra_data;
  logic [31:0]                      rb_data;
  mtrd_pkg::res_req_t               req;

  // Seed register takes every write
  assign cfg_ready = 1'b1;

  mtrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .ra_addr   (ra_addr),
    .rb_addr   (rb_addr),
    .ra_data   (ra_data),
    .rb_data   (rb_data),
    .req       (req)
  );

  mtrd_state_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  mtrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_word   (ra_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;

  // Generator constants, kept apart from the package so the prediction stands alone
  localparam int unsigned WordCount   = 624;
  localparam int unsigned FarOffset   = 397;
  localparam logic [31:0] TwistMatrix = 32'h9908_b0df;
  localparam logic [31:0] UpperBit    = 32'h8000_0000;
  localparam logic [31:0] LowerBits   = 32'h7fff_ffff;
  localparam logic [31:0] TemperMaskB = 32'h9d2c_5680;
  localparam logic [31:0] TemperMaskC = 32'hefc6_0000;
  localparam logic [31:0] SeedMult    = 32'd1812433253;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 10000;
  localparam int unsigned PhaseItems   = 322;

  // Mirror of the generator state; queues the draw each accepted request should yield
  class twister_scoreboard;
    logic [31:0] pool [WordCount];
    int unsigned remaining;
    int unsigned next_idx;
    bit          is_seeded;
    logic [31:0] seed_reg;
    mtrd_pkg::out_item_t pending_draws [$];
    int unsigned errors;

    function new();
      foreach (pool[i]) pool[i] = '0;
      remaining = 1;
      next_idx  = 0;
      is_seeded = 1'b0;
      seed_reg  = mtrd_pkg::DefaultSeed;
      errors    = 0;
    endfunction

    // Append one expected result to the tail of the queue
    function void queue_draw(input mtrd_pkg::out_item_t d);
      pending_draws.insert(pending_draws.size(), d);
    endfunction

    // Fill the pool from a seed with the usual initialisation recurrence
    function void load_seed(input logic [31:0] s);
      int unsigned j;
      pool[0] = s;
      for (j = 1; j < WordCount; j++) begin
        pool[j] = SeedMult * (pool[j-1] ^ (pool[j-1] >> 30)) + 32'(j);
      end
      remaining = 1;
      is_seeded = 1'b1;
    endfunction

    function void accept_request(input mtrd_pkg::in_item_t req);
      int unsigned k;
      logic [31:0] y;
      logic [31:0] mix;
      logic [31:0] nxt;
      logic [31:0] far;
      logic [63:0] prod;
      mtrd_pkg::out_item_t want;
      if (req.action == mtrd_pkg::ActReseed) begin
        load_seed(seed_reg);
        queue_draw('0);
      end else begin
        remaining = (remaining - 1) & 32'h3ff;
        // Regenerate the whole pool once it is used up, seeding first if never seeded
        if (remaining == 0) begin
          if (!is_seeded) load_seed(mtrd_pkg::DefaultSeed);
          remaining = WordCount;
          next_idx  = 0;
          for (k = 0; k < WordCount; k++) begin
            nxt = pool[(k + 1) % WordCount];
            far = pool[(k + FarOffset) % WordCount];
            mix = (pool[k] & UpperBit) | (nxt & LowerBits);
            pool[k] = far ^ (mix >> 1) ^ (nxt[0] ? TwistMatrix : 32'h0);
          end
        end
        y = pool[next_idx % WordCount];
        next_idx = (next_idx + 1) & 32'h3ff;
        // Temper the word
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperMaskB);
        y = y ^ ((y << 15) & TemperMaskC);
        y = y ^ (y >> 18);
        // Scale into the range with the exact 64-bit product
        prod = {32'h0, y} * {33'h0, req.range_limit};
        want.raw_word     = y;
        want.ranged_value = prod[62:32];
        queue_draw(want);
      end
    endfunction

    function void flag(input string field, input logic [31:0] want, input logic [31:0] got);
      errors++;
      if (errors <= 10)
        $display("draw mismatch on %s: expected %08h, got %08h", field, want, got);
    endfunction

    function void check_draw(input mtrd_pkg::out_item_t got);
      mtrd_pkg::out_item_t want;
      if (pending_draws.size() == 0) begin
        flag("unexpected result", 32'h0, got.raw_word);
      end else begin
        want = pending_draws.pop_front();
        if (got.ranged_value !== want.ranged_value)
          flag("ranged_value", {1'b0, want.ranged_value}, {1'b0, got.ranged_value});
        if (got.raw_word !== want.raw_word)
          flag("raw_word", want.raw_word, got.raw_word);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  mtrd_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  mtrd_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [31:0]         cfg_data  = '0;

  twister_scoreboard sb;
  int unsigned quiet_cycles = 0;

  mersenne_twister_ranged_draw_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Observe handshakes at each edge and guard against a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_draw(out_data);
      if (start && !busy) sb.accept_request(in_data);
      if (cfg_valid && cfg_ready) sb.seed_reg = cfg_data;
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("mersenne_twister_ranged_draw_top regression: fail");
          $finish;
        end
      end
    end
  end

  // Present one request, idling beforehand at the given rate, and hold it until taken
  task automatic send_request(input mtrd_pkg::in_item_t req, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every draw has come back and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (sb.pending_draws.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reseed from the new seed, then mostly draws with the odd reseed mixed in
  task automatic run_phase(input int unsigned count, input int unsigned idle_pct);
    mtrd_pkg::in_item_t req;
    req.action      = mtrd_pkg::ActReseed;
    req.range_limit = 31'($urandom());
    send_request(req, idle_pct);
    repeat (count) begin
      req.action = ($urandom_range(0, 99) < 3) ? mtrd_pkg::ActReseed : mtrd_pkg::ActDraw;
      case ($urandom_range(0, 7))
        0: begin
          req.range_limit = '0;
        end
        1: begin
          req.range_limit = 31'h7fff_ffff;
        end
        2: begin
          req.range_limit = 31'($urandom_range(1, 64));
        end
        default: begin
          req.range_limit = 31'($urandom());
        end
      endcase
      send_request(req, idle_pct);
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Draws before any reseed use the default seed; then reseed from the reset seed value
    send_request({mtrd_pkg::ActDraw,   31'h7fff_ffff}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h0000_0000}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h0000_0001}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h4000_0000}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h2aaa_aaaa}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h5555_5555}, 0);
    send_request({mtrd_pkg::ActReseed, 31'h7fff_ffff}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h7fff_ffff}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h0000_0000}, 0);
    send_request({mtrd_pkg::ActReseed, 31'h0000_0000}, 0);
    send_request({mtrd_pkg::ActReseed, 31'h1234_5678}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h0000_0001}, 0);
    send_request({mtrd_pkg::ActDraw,   31'h7fff_fffe}, 0);
    settle();

    // Phases: no idling, sender idle often, no idling, sender idle now and then
    write_seed(32'h0000_0000);
    run_phase(PhaseItems, 0);
    write_seed(32'hffff_ffff);
    run_phase(PhaseItems, 65);
    write_seed($urandom());
    run_phase(PhaseItems, 0);
    write_seed($urandom());
    run_phase(PhaseItems, 8);

    if (sb.errors == 0 && sb.pending_draws.size() == 0) begin
      $display("mersenne_twister_ranged_draw_top regression: pass");
    end else begin
      $display("mersenne_twister_ranged_draw_top regression: fail");
    end
    $finish;
  end

endmodule
